// File: rtl/core/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared types, widths and codes of the broadcast byte bus FIFO block.
// ----------------------------------------------------------------------------
package bbf_pkg;

    localparam int NUM_PORTS_DEF  = 8;
    localparam int FIFO_DEPTH_DEF = 256;

    localparam int PORT_W     = 3;
    localparam int DATA_W     = 8;
    localparam int PIN_W      = 4;
    localparam int COUNT_W    = 9;
    localparam int COUNT_MAX  = 511;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // s_tuser = {port, func}, s_tdata = data
    localparam int IN_USER_W  = 4;
    localparam int IN_DATA_W  = 8;
    // m_tuser = port_out, m_tdata = {6'b0, accepted_count, ok, read_byte}
    localparam int OUT_USER_W = 3;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PORTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_OWN     = 2'd1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef struct packed {
        logic load_in;
        logic exec_wr;
        logic exec_rd;
        logic load_out_wr;
        logic load_out_rd;
    } cmd_t;

    typedef struct packed {
        logic is_read;
    } stat_t;

endpackage

// File: rtl/core/bbf_bank.sv
// ----------------------------------------------------------------------------
// bbf_bank
// One port's receive FIFO: byte memory with head, tail and fill level.
// ----------------------------------------------------------------------------
module bbf_bank #(
    parameter int FIFO_DEPTH = bbf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [bbf_pkg::DATA_W-1:0] wdata,
    input  logic                      pop,
    output logic                      full,
    output logic                      empty,
    output logic [bbf_pkg::DATA_W-1:0] rdata
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int LW = $clog2(FIFO_DEPTH + 1);

    logic [bbf_pkg::DATA_W-1:0] mem [FIFO_DEPTH];
    logic [bbf_pkg::DATA_W-1:0] rdata_reg;
    logic [AW-1:0]              head_reg;
    logic [AW-1:0]              head_next;
    logic [AW-1:0]              tail_reg;
    logic [AW-1:0]              tail_next;
    logic [LW-1:0]              fill_reg;
    logic [LW-1:0]              fill_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= wdata;
        end
        if (pop)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (pop)
        begin
            head_next = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
        else if (push)
        begin
            tail_next = (tail_reg == AW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    assign full  = (fill_reg == LW'(FIFO_DEPTH));
    assign empty = (fill_reg == '0);
    assign rdata = rdata_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LW'(FIFO_DEPTH))
        else $error("bank fill level above depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full bank");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty bank");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (head_reg == tail_reg))
        else $error("head and tail out of step with fill level");

endmodule

// File: rtl/core/bbf_ctrl.sv
// ----------------------------------------------------------------------------
// bbf_ctrl
// Sequencer: take a beat, run the write or read, hand the result out.
// ----------------------------------------------------------------------------
module bbf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  bbf_pkg::stat_t stat,
    output bbf_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // the output register must be free before any state changes
                if (out_free)
                begin
                    if (stat.is_read)
                    begin
                        cmd.exec_rd = 1'b1;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        cmd.exec_wr     = 1'b1;
                        cmd.load_out_wr = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                cmd.load_out_rd = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (cmd.load_out_wr || cmd.load_out_rd) ? 1'b1 :
                            (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(cmd.exec_rd))
        else $error("read state entered without a read issue");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out_wr || cmd.load_out_rd) |-> (!out_valid_reg || m_tready))
        else $error("result overwrites a beat not yet taken");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec_wr && cmd.exec_rd))
        else $error("write and read issued together");

endmodule

// File: rtl/core/bbf_dpath.sv
// ----------------------------------------------------------------------------
// bbf_dpath
// Datapath: config registers, per-port banks, message state, result register.
// ----------------------------------------------------------------------------
module bbf_dpath #(
    parameter int NUM_PORTS  = bbf_pkg::NUM_PORTS_DEF,
    parameter int FIFO_DEPTH = bbf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bbf_pkg::cmd_t                     cmd,
    output bbf_pkg::stat_t                    stat,
    input  logic                              cfg_valid,
    input  logic [bbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bbf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [bbf_pkg::IN_USER_W-1:0]     s_tuser,
    input  logic [bbf_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    output logic [bbf_pkg::OUT_USER_W-1:0]    m_tuser,
    output logic [bbf_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    localparam int LW  = $clog2(FIFO_DEPTH + 1);
    localparam int NJW = $clog2(NUM_PORTS + 1);
    localparam int JW  = (NJW > bbf_pkg::PIN_W) ? NJW : bbf_pkg::PIN_W;
    localparam int MW  = (LW > bbf_pkg::COUNT_W) ? LW : bbf_pkg::COUNT_W;

    // configuration
    logic [bbf_pkg::PIN_W-1:0] pin_reg;
    logic                      echo_reg;

    // captured beat
    logic                        func_reg;
    logic [bbf_pkg::PORT_W-1:0]  port_reg;
    logic [bbf_pkg::DATA_W-1:0]  data_reg;
    logic                        last_reg;

    // message state
    logic [LW-1:0] msg_cnt_reg;
    logic [LW-1:0] msg_cnt_next;
    logic          msg_cut_reg;
    logic          msg_cut_next;

    logic                        rd_hit_reg;
    logic [bbf_pkg::PORT_W-1:0]  out_port_reg;
    logic [bbf_pkg::DATA_W-1:0]  out_byte_reg;
    logic                        out_ok_reg;
    logic                        out_done_reg;
    logic [bbf_pkg::COUNT_W-1:0] out_cnt_reg;

    logic [JW-1:0]              joined;
    logic [NUM_PORTS-1:0]       joined_vec;
    logic [NUM_PORTS-1:0]       sel_vec;
    logic [NUM_PORTS-1:0]       target_vec;
    logic [NUM_PORTS-1:0]       full_vec;
    logic [NUM_PORTS-1:0]       empty_vec;
    logic [NUM_PORTS-1:0]       push_vec;
    logic [NUM_PORTS-1:0]       pop_vec;
    logic [bbf_pkg::DATA_W-1:0] rdata_arr [NUM_PORTS];
    logic [bbf_pkg::DATA_W-1:0] rd_byte;
    logic                       rd_hit;
    logic                       room;
    logic [LW-1:0]              cnt_inc;
    logic [MW-1:0]              cnt_wide;
    logic [bbf_pkg::COUNT_W-1:0] cnt_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_reg  <= '0;
            echo_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == bbf_pkg::REG_PORTS_IN_USE)
            begin
                pin_reg <= cfg_data;
            end
            else if (cfg_index == bbf_pkg::REG_ECHO_OWN)
            begin
                echo_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= s_tuser[0];
            port_reg <= s_tuser[bbf_pkg::PORT_W:1];
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign stat.is_read = (func_reg == bbf_pkg::FUNC_READ);

    // ports_in_use beyond the bank count is clamped
    assign joined = (JW'(pin_reg) > JW'(NUM_PORTS)) ? JW'(NUM_PORTS) : JW'(pin_reg);

    always_comb
    begin
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            joined_vec[i] = (JW'(i) < joined);
            sel_vec[i]    = (JW'(i) == JW'(port_reg));
            target_vec[i] = joined_vec[i] && (!sel_vec[i] || echo_reg);
        end
    end

    assign room   = !msg_cut_reg && (msg_cnt_reg < LW'(FIFO_DEPTH)) &&
                    !(|(target_vec & full_vec));
    assign rd_hit = |(sel_vec & joined_vec & ~empty_vec);

    assign push_vec = (cmd.exec_wr && room) ? target_vec : '0;
    assign pop_vec  = (cmd.exec_rd && rd_hit) ? sel_vec : '0;

    for (genvar g = 0; g < NUM_PORTS; g++)
    begin : g_bank
        bbf_bank #(
            .FIFO_DEPTH (FIFO_DEPTH)
        ) u_bank (
            .clk   (clk),
            .rst_n (rst_n),
            .push  (push_vec[g]),
            .wdata (data_reg),
            .pop   (pop_vec[g]),
            .full  (full_vec[g]),
            .empty (empty_vec[g]),
            .rdata (rdata_arr[g])
        );
    end

    always_comb
    begin
        rd_byte = '0;
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            rd_byte = rd_byte | (sel_vec[i] ? rdata_arr[i] : '0);
        end
    end

    // count including this beat; room implies it stays within depth
    assign cnt_inc  = msg_cnt_reg + LW'(room);
    assign cnt_wide = MW'(cnt_inc);
    assign cnt_sat  = (cnt_wide > MW'(bbf_pkg::COUNT_MAX)) ?
                      bbf_pkg::COUNT_W'(bbf_pkg::COUNT_MAX) :
                      cnt_wide[bbf_pkg::COUNT_W-1:0];

    always_comb
    begin
        msg_cnt_next = msg_cnt_reg;
        msg_cut_next = msg_cut_reg;
        if (cmd.exec_wr)
        begin
            if (last_reg)
            begin
                msg_cnt_next = '0;
                msg_cut_next = 1'b0;
            end
            else
            begin
                msg_cnt_next = cnt_inc;
                msg_cut_next = msg_cut_reg || !room;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_cnt_reg <= '0;
            msg_cut_reg <= 1'b0;
        end
        else
        begin
            msg_cnt_reg <= msg_cnt_next;
            msg_cut_reg <= msg_cut_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_rd)
        begin
            rd_hit_reg <= rd_hit;
        end
        if (cmd.load_out_wr)
        begin
            out_port_reg <= port_reg;
            out_byte_reg <= '0;
            out_ok_reg   <= room;
            out_done_reg <= last_reg;
            out_cnt_reg  <= last_reg ? cnt_sat : '0;
        end
        else if (cmd.load_out_rd)
        begin
            out_port_reg <= port_reg;
            out_byte_reg <= rd_hit_reg ? rd_byte : '0;
            out_ok_reg   <= rd_hit_reg;
            out_done_reg <= 1'b0;
            out_cnt_reg  <= '0;
        end
    end

    assign m_tuser = out_port_reg;
    assign m_tdata = {6'b0, out_cnt_reg, out_ok_reg, out_byte_reg};
    assign m_tlast = out_done_reg;

    a_write_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        msg_cnt_reg <= LW'(FIFO_DEPTH))
        else $error("message count above depth");

    a_cut_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec_wr && msg_cut_reg) |-> (push_vec == '0))
        else $error("byte stored after message was cut");

    a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(pop_vec))
        else $error("more than one bank popped");

endmodule

// File: rtl/core/broadcast_byte_bus_fifos.sv
// ----------------------------------------------------------------------------
// broadcast_byte_bus_fifos
// Shared byte bus with one receive FIFO per port. Each input beat is either a
// write (broadcast of one byte to every joined port, and to the writer too
// when echo is on, accepted only if all targets have room) or a read (pop one
// byte from the port's own FIFO). Every beat returns exactly one result beat;
// the last beat of a write message (tlast) reports the accepted byte count.
// A write passes through the accept and execute steps and a read through the
// read step as well: the accepting cycle captures the beat, the execute cycle
// checks room across all banks and writes them in parallel (or issues the
// bank read), and the read step takes the registered memory output. The
// result register is loaded from the execute step for a write and from the
// read step for a read. A new beat is taken once the previous one has been
// loaded into the result register; a stalled result holds the block in its
// execute step until it is taken. No clearing pass after reset: FIFO fill
// levels reset to zero and memory contents are never read unwritten.
// ----------------------------------------------------------------------------
module broadcast_byte_bus_fifos #(
    parameter int NUM_PORTS  = bbf_pkg::NUM_PORTS_DEF,
    parameter int FIFO_DEPTH = bbf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bbf_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] data
    input  logic [bbf_pkg::IN_USER_W-1:0]  s_tuser,   // [0] func, [3:1] port
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bbf_pkg::OUT_DATA_W-1:0] m_tdata,   // [7:0] read_byte, [8] ok,
                                                      // [17:9] accepted_count
    output logic [bbf_pkg::OUT_USER_W-1:0] m_tuser,   // [2:0] port_out
    output logic                           m_tlast    // done_res
);

    bbf_pkg::cmd_t  cmd;
    bbf_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    bbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bbf_dpath #(
        .NUM_PORTS  (NUM_PORTS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
